// File: rtl/core/bis_pkg.sv
// Shared types and constants of the bilinear image scaler.
`default_nettype none

package bis_pkg;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 9;
    localparam int STEP_W  = 25;
    localparam int COORD_W = 10;
    localparam int FRAC_W  = 8;
    localparam int MUL_A_W = STEP_W + 1;
    localparam int MUL_B_W = COORD_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int POS_W   = COORD_W + STEP_W;
    localparam int CFG_IDX_W = 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 2'd3;

    localparam logic [DIM_W-1:0]  DIM_RESET  = 9'd256;
    localparam logic [STEP_W-1:0] STEP_RESET = 25'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_CHK_Y,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_LERP_D,
        ST_LERP_M2,
        ST_LERP_P,
        ST_LERP_FIN
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/bis_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/bis_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module bis_mul
    import bis_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [MUL_A_W-1:0]  a,
    input  wire logic signed [MUL_B_W-1:0]  b,
    output logic      signed [PROD_W-1:0]   prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

// File: rtl/core/bis_axis.sv
// Maps a scaled position to a neighbour index and fraction, with range check.
`default_nettype none

module bis_axis
    import bis_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  wire logic [POS_W-1:0]           pos,
    input  wire logic [DIM_W-1:0]           size,
    output logic                            err,
    output logic [FRAC_W-1:0]               frac,
    output logic [$clog2(MAX_DIM)-1:0]      ipos
);

    localparam int IP_W = POS_W - 16;
    localparam logic [IP_W:0] MAX_D = (IP_W + 1)'(MAX_DIM);

    logic [IP_W-1:0] ip;
    logic [IP_W:0]   ip_ext;
    logic [IP_W:0]   ip_inc;
    logic [IP_W:0]   size_ext;
    logic [IP_W-1:0] ip_adj;
    logic            moved;

    always_comb
    begin
        ip       = pos[POS_W-1:16];
        ip_ext   = {1'b0, ip};
        ip_inc   = ip_ext + 1'b1;
        size_ext = (IP_W + 1)'(size);
        frac     = pos[15:8];
        // at or past the last column/row: step back one whole pixel
        moved    = (ip_inc >= size_ext);
        if (moved)
        begin
            ip_adj = ip - 1'b1;
            err    = (ip == '0) || (ip_ext >= size_ext) || (ip_ext >= MAX_D);
        end
        else
        begin
            ip_adj = ip;
            err    = (ip_inc >= MAX_D);
        end
        ipos = ip_adj[$clog2(MAX_DIM)-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/core/bilinear_image_scaler.sv
// Top level: bilinear grayscale scaler with image store and query sequencer.
`default_nettype none

// A load item (req_type 0) writes one source pixel in the cycle it is accepted and leaves
// busy low, so loads can be issued every cycle. A query item (req_type 1) holds busy high
// while it does two multiplies for the position mapping, four reads of the single-port
// image memory, and three interpolation multiplies, all on one shared multiplier. A query
// whose neighbours fall outside the image stops after the mapping and does no memory reads.
// The result appears for one cycle with out_valid in the first cycle that busy is low again;
// the receiver cannot stall it, and a new item may be started in that same cycle. Loads
// outside the store are dropped. Pixels never loaded read back as unknown.
// Configuration writes are always ready and must only be issued while no query is in flight.
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 req_type,
    input  wire logic [7:0]           src_col,
    input  wire logic [7:0]           src_row,
    input  wire logic [PIX_W-1:0]     src_pixel,
    input  wire logic [COORD_W-1:0]   dst_col,
    input  wire logic [COORD_W-1:0]   dst_row,
    output logic                      out_valid,
    output logic [PIX_W-1:0]          out_pixel,
    output logic                      range_error,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [STEP_W-1:0]    cfg_data
);

    localparam int CW    = $clog2(MAX_SRC_WIDTH);
    localparam int RW    = $clog2(MAX_SRC_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic [12:0] MAX_W13 = 13'(MAX_SRC_WIDTH);
    localparam logic [12:0] MAX_H13 = 13'(MAX_SRC_HEIGHT);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   src_width_reg, src_height_reg;
    logic [STEP_W-1:0]  step_x_reg, step_y_reg;
    logic [COORD_W-1:0] dst_col_reg, dst_row_reg;
    logic [CW-1:0]      cx_reg;
    logic [RW-1:0]      ry_reg;
    logic [FRAC_W-1:0]  fx_reg, fy_reg;
    logic               errx_reg;
    logic [PIX_W-1:0]   a_reg, b_reg, c_reg, m1_reg, m2_reg;

    logic               accept;
    logic               load_we;
    logic [AW-1:0]      ram_addr;
    logic [PIX_W-1:0]   ram_rdata;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic              ax_err, ay_err;
    logic [FRAC_W-1:0] ax_frac, ay_frac;
    logic [CW-1:0]     ax_ipos;
    logic [RW-1:0]     ay_ipos;

    logic signed [8:0]  diff;
    logic signed [17:0] rnd_sum;
    logic signed [9:0]  rnd_q;
    logic signed [10:0] lerp_sum;
    logic [PIX_W-1:0]   lerp_base;
    logic [PIX_W-1:0]   lerp_out;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign load_we   = accept && (req_type == REQ_LOAD)
                       && (13'(src_col) < MAX_W13) && (13'(src_row) < MAX_H13);

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .addr  (ram_addr),
        .wdata (src_pixel),
        .rdata (ram_rdata)
    );

    bis_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    bis_axis #(
        .MAX_DIM (MAX_SRC_WIDTH)
    ) u_axis_x (
        .pos  (prod_reg[POS_W-1:0]),
        .size (src_width_reg),
        .err  (ax_err),
        .frac (ax_frac),
        .ipos (ax_ipos)
    );

    bis_axis #(
        .MAX_DIM (MAX_SRC_HEIGHT)
    ) u_axis_y (
        .pos  (prod_reg[POS_W-1:0]),
        .size (src_height_reg),
        .err  (ay_err),
        .frac (ay_frac),
        .ipos (ay_ipos)
    );

    // memory address: neighbour reads in the four read states, load address otherwise
    always_comb
    begin
        unique case (state_reg)
            ST_RD_A: ram_addr = {ry_reg, cx_reg};
            ST_RD_B: ram_addr = {RW'(ry_reg + 1'b1), cx_reg};
            ST_RD_C: ram_addr = {ry_reg, CW'(cx_reg + 1'b1)};
            ST_RD_D: ram_addr = {RW'(ry_reg + 1'b1), CW'(cx_reg + 1'b1)};
            default: ram_addr = {RW'(src_row), CW'(src_col)};
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        diff  = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_X:
            begin
                mul_a = signed'({1'b0, step_x_reg});
                mul_b = signed'({1'b0, dst_col_reg});
            end
            ST_MUL_Y:
            begin
                mul_a = signed'({1'b0, step_y_reg});
                mul_b = signed'({1'b0, dst_row_reg});
            end
            ST_RD_D:
            begin
                diff  = signed'({1'b0, b_reg}) - signed'({1'b0, a_reg});
                mul_a = MUL_A_W'(diff);
                mul_b = signed'({3'b0, fy_reg});
            end
            ST_LERP_D:
            begin
                diff  = signed'({1'b0, ram_rdata}) - signed'({1'b0, c_reg});
                mul_a = MUL_A_W'(diff);
                mul_b = signed'({3'b0, fy_reg});
            end
            ST_LERP_P:
            begin
                diff  = signed'({1'b0, m2_reg}) - signed'({1'b0, m1_reg});
                mul_a = MUL_A_W'(diff);
                mul_b = signed'({3'b0, fx_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // base + product/256 rounded half up, clamped to pixel range
    always_comb
    begin
        case (state_reg)
            ST_LERP_D:  lerp_base = a_reg;
            ST_LERP_M2: lerp_base = c_reg;
            default:    lerp_base = m1_reg;
        endcase
        rnd_sum  = signed'(prod_reg[17:0]) + 18'sd128;
        rnd_q    = rnd_sum[17:8];
        lerp_sum = signed'({3'b0, lerp_base}) + 11'(rnd_q);
        if (lerp_sum < 0)
        begin
            lerp_out = '0;
        end
        else if (lerp_sum > 11'sd255)
        begin
            lerp_out = 8'd255;
        end
        else
        begin
            lerp_out = lerp_sum[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_QUERY))
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:    state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_CHK_Y;
            ST_CHK_Y:    state_next = (errx_reg || ay_err) ? ST_IDLE : ST_RD_A;
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = ST_RD_C;
            ST_RD_C:     state_next = ST_RD_D;
            ST_RD_D:     state_next = ST_LERP_D;
            ST_LERP_D:   state_next = ST_LERP_M2;
            ST_LERP_M2:  state_next = ST_LERP_P;
            ST_LERP_P:   state_next = ST_LERP_FIN;
            ST_LERP_FIN: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid      <= 1'b0;
            src_width_reg  <= DIM_RESET;
            src_height_reg <= DIM_RESET;
            step_x_reg     <= STEP_RESET;
            step_y_reg     <= STEP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= ((state_reg == ST_CHK_Y) && (errx_reg || ay_err))
                         || (state_reg == ST_LERP_FIN);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_SRC_HEIGHT: src_height_reg <= cfg_data[DIM_W-1:0];
                    CFG_STEP_X:     step_x_reg     <= cfg_data;
                    CFG_STEP_Y:     step_y_reg     <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dst_col_reg <= dst_col;
            dst_row_reg <= dst_row;
        end
        case (state_reg)
            ST_MUL_Y:
            begin
                cx_reg   <= ax_ipos;
                fx_reg   <= ax_frac;
                errx_reg <= ax_err;
            end
            ST_CHK_Y:
            begin
                ry_reg <= ay_ipos;
                fy_reg <= ay_frac;
                if (errx_reg || ay_err)
                begin
                    out_pixel   <= '0;
                    range_error <= 1'b1;
                end
            end
            ST_RD_B:     a_reg  <= ram_rdata;
            ST_RD_C:     b_reg  <= ram_rdata;
            ST_RD_D:     c_reg  <= ram_rdata;
            ST_LERP_D:   m1_reg <= lerp_out;
            ST_LERP_M2:  m2_reg <= lerp_out;
            ST_LERP_FIN:
            begin
                out_pixel   <= lerp_out;
                range_error <= 1'b0;
            end
            default:     ;
        endcase
    end

endmodule

`default_nettype wire
